>>> hw/rtl/assert_macros.svh
// Shared assertion macros for the codec checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define KVC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: property does not hold");

// Next-cycle implication, ignored while reset is held.
`define KVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: property does not hold");

`endif

>>> hw/rtl/kvc_pkg.sv
package kvc_pkg;

  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 8;

  // Largest column index that a key may select; larger requests are clamped.
  localparam logic [COL_W-1:0] MAX_COLUMN = 8'hff;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

endpackage

>>> hw/rtl/kvc_if.sv
interface kvc_in_if import kvc_pkg::*;;
  logic               valid;
  logic               ready;
  req_t               req_type;
  logic [VALUE_W-1:0] value_in;
  logic [BYTE_W-1:0]  byte_in;
  logic [COL_W-1:0]   column;
  logic               key_end;

  modport source (output valid, req_type, value_in, byte_in, column, key_end, input ready);
  modport sink   (input valid, req_type, value_in, byte_in, column, key_end, output ready);
endinterface

interface kvc_out_if import kvc_pkg::*;;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [BYTE_W-1:0]  byte_out;
  logic [VALUE_W-1:0] value_out;
  logic               last;

  modport source (output valid, kind, byte_out, value_out, last, input ready);
  modport sink   (input valid, kind, byte_out, value_out, last, output ready);
endinterface

>>> hw/rtl/key_varint_codec_core.sv
// An item is taken into the input register; its first result, if it has one, is then loaded
// into the output register and is offered from there until it is taken.
// A decode item is retired on its first step. An encode item yields 1 to 9 encoded bytes, and
// the single output register carries one byte per cycle while out_chan is not stalled.
// Reset: synchronous, active low; it empties both registers and clears the key state.
module key_varint_codec_core import kvc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  kvc_in_if.sink       in_chan,
  kvc_out_if.source    out_chan
);

  // Input register.
  logic               s_valid_r, s_valid_nxt;
  req_t               s_req_r;
  logic [VALUE_W-1:0] s_value_r;
  logic [BYTE_W-1:0]  s_byte_r;
  logic [COL_W-1:0]   s_col_r;
  logic               s_end_r;
  logic [3:0]         enc_idx_r, enc_idx_nxt;

  // Output register.
  logic               o_valid_r, o_valid_nxt;
  kind_t              o_kind_r;
  logic [BYTE_W-1:0]  o_byte_r;
  logic [VALUE_W-1:0] o_value_r;
  logic               o_last_r;

  // Key decode state.
  logic [COL_W-1:0]   tgt_r, tgt_nxt;
  logic [COL_W-1:0]   passed_r, passed_nxt;
  logic [3:0]         bl_r, bl_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               done_r, done_nxt;
  logic               started_r, started_nxt;

  logic in_fire, out_free, has_res, step, retire;

  // Encoder signals.
  logic [2:0]        enc_rem;
  logic              enc_nz;
  logic [BYTE_W-1:0] enc_y;
  logic [3:0]        enc_top;
  logic [BYTE_W-1:0] enc_hdr;
  logic [3:0]        enc_pos;
  logic [BYTE_W-1:0] enc_byte;
  logic              enc_last;

  // Decoder signals.
  logic [COL_W-1:0]   d_tgt, d_passed;
  logic [3:0]         d_bl;
  logic [VALUE_W-1:0] d_acc;
  logic               d_done, d_chosen, d_complete;
  logic               dec_has_res;
  kind_t              dec_kind;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !o_valid_r || out_chan.ready;

  // Locate the most significant nonzero byte of the value and pick the encoded byte to send.
  always_comb begin
    enc_rem = 3'd0;
    enc_nz  = 1'b0;
    for (int r = 0; r < 8; r++) begin
      if (s_value_r[r*BYTE_W +: BYTE_W] != '0) begin
        enc_rem = 3'(r);
        enc_nz  = 1'b1;
      end
    end
    enc_y = s_value_r[{enc_rem, 3'b000} +: BYTE_W];
    if (!enc_nz) begin
      enc_top = 4'd0;
      enc_hdr = 8'h00;
    end else if (enc_y <= 8'h0f) begin
      enc_top = {1'b0, enc_rem};
      enc_hdr = {1'b0, enc_rem, enc_y[3:0]};
    end else begin
      enc_top = {1'b0, enc_rem} + 4'd1;
      enc_hdr = {({1'b0, enc_rem} + 4'd1), 4'h0};
    end
    enc_pos  = enc_top - enc_idx_r;
    enc_byte = (enc_idx_r == 4'd0) ? enc_hdr : s_value_r[{enc_pos[2:0], 3'b000} +: BYTE_W];
    enc_last = (enc_idx_r == enc_top);
  end

  // One key byte against the decode state; the first byte of a key starts from a clean state.
  always_comb begin
    if (started_r) begin
      d_tgt    = tgt_r;
      d_passed = passed_r;
      d_bl     = bl_r;
      d_acc    = acc_r;
      d_done   = done_r;
    end else begin
      d_tgt    = (s_col_r > MAX_COLUMN) ? MAX_COLUMN : s_col_r;
      d_passed = '0;
      d_bl     = '0;
      d_acc    = '0;
      d_done   = 1'b0;
    end
    tgt_nxt     = d_tgt;
    passed_nxt  = d_passed;
    bl_nxt      = d_bl;
    acc_nxt     = d_acc;
    done_nxt    = d_done;
    d_chosen    = (d_passed == d_tgt);
    d_complete  = 1'b0;
    dec_has_res = 1'b0;
    dec_kind    = KIND_VALUE;
    if (!d_done) begin
      if (d_bl == 4'd0) begin
        if (d_chosen) begin
          acc_nxt = {{(VALUE_W-4){1'b0}}, s_byte_r[3:0]};
        end
        bl_nxt     = s_byte_r[7:4];
        d_complete = (s_byte_r[7:4] == 4'd0);
      end else begin
        bl_nxt = d_bl - 4'd1;
        if (d_chosen) begin
          // High bits of over-long varints fall off the top.
          acc_nxt = {d_acc[VALUE_W-BYTE_W-1:0], s_byte_r};
        end
        d_complete = (bl_nxt == 4'd0);
      end
      if (d_complete) begin
        if (d_chosen) begin
          done_nxt    = 1'b1;
          dec_has_res = 1'b1;
        end else begin
          passed_nxt = d_passed + 8'd1;
        end
      end
    end
    if (s_end_r && !done_nxt) begin
      dec_has_res = 1'b1;
      dec_kind    = KIND_SHORT;
    end
    started_nxt = !s_end_r;
  end

  always_comb begin
    has_res = (s_req_r == REQ_ENCODE) ? 1'b1 : dec_has_res;
    step    = s_valid_r && (!has_res || out_free);
    retire  = step && ((s_req_r == REQ_ENCODE) ? enc_last : 1'b1);
    in_chan.ready = !s_valid_r || retire;

    s_valid_nxt = in_fire ? 1'b1 : (retire ? 1'b0 : s_valid_r);
    enc_idx_nxt = enc_idx_r;
    if (step && s_req_r == REQ_ENCODE) begin
      enc_idx_nxt = enc_last ? 4'd0 : enc_idx_r + 4'd1;
    end
    o_valid_nxt = (step && has_res) ? 1'b1 : (out_chan.ready ? 1'b0 : o_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      enc_idx_r <= '0;
      o_valid_r <= 1'b0;
      tgt_r     <= '0;
      passed_r  <= '0;
      bl_r      <= '0;
      acc_r     <= '0;
      done_r    <= 1'b0;
      started_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      enc_idx_r <= enc_idx_nxt;
      o_valid_r <= o_valid_nxt;
      if (step && s_req_r == REQ_DECODE) begin
        tgt_r     <= tgt_nxt;
        passed_r  <= passed_nxt;
        bl_r      <= bl_nxt;
        acc_r     <= acc_nxt;
        done_r    <= done_nxt;
        started_r <= started_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_req_r   <= in_chan.req_type;
      s_value_r <= in_chan.value_in;
      s_byte_r  <= in_chan.byte_in;
      s_col_r   <= in_chan.column;
      s_end_r   <= in_chan.key_end;
    end
    if (step && has_res) begin
      if (s_req_r == REQ_ENCODE) begin
        o_kind_r  <= KIND_BYTE;
        o_byte_r  <= enc_byte;
        o_value_r <= '0;
        o_last_r  <= enc_last;
      end else begin
        o_kind_r  <= dec_kind;
        o_byte_r  <= '0;
        o_value_r <= (dec_kind == KIND_VALUE) ? acc_nxt : '0;
        o_last_r  <= 1'b1;
      end
    end
  end

  assign out_chan.valid     = o_valid_r;
  assign out_chan.kind      = o_kind_r;
  assign out_chan.byte_out  = o_byte_r;
  assign out_chan.value_out = o_value_r;
  assign out_chan.last      = o_last_r;

endmodule

>>> hw/rtl/kvc_checker.sv
`include "assert_macros.svh"

module kvc_checker import kvc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  kvc_out_if.source  out_chan
);

  // A stalled result keeps its contents.
  `KVC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_chan.valid && !out_chan.ready, out_chan.valid && $stable(out_chan.kind) && $stable(out_chan.value_out) && $stable(out_chan.byte_out))

  // Decode results always close their item.
  `KVC_ASSERT_IMPL(a_dec_last, clk, rst_n, out_chan.valid && out_chan.kind != KIND_BYTE, out_chan.last)

  // Only a decoded value carries a value.
  `KVC_ASSERT_IMPL(a_val_zero, clk, rst_n, out_chan.valid && out_chan.kind != KIND_VALUE, out_chan.value_out == '0)

  // An encoding streams without gaps until its final byte.
  `KVC_ASSERT_NEXT(a_enc_gapless, clk, rst_n, out_chan.valid && out_chan.kind == KIND_BYTE && !out_chan.last, out_chan.valid && out_chan.kind == KIND_BYTE)

endmodule

bind key_varint_codec_core kvc_checker u_kvc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_chan (out_chan)
);
